/* hw/rtl/best_fit_region_allocator_unit_defines.svh */
// Assertion macros for the region allocator.
`ifndef BEST_FIT_REGION_ALLOCATOR_UNIT_DEFINES_SVH
`define BEST_FIT_REGION_ALLOCATOR_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define BFRA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BFRA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BFRA_ASSERT(lbl, clk, rst_n, prop, msg)
`define BFRA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* hw/rtl/bfra_pkg.sv */
package bfra_pkg;

  localparam int MAX_BLOCKS  = 64;
  localparam int GRAIN_BYTES = 4096;
  localparam int IDX_W       = $clog2(MAX_BLOCKS);
  localparam int CNT_W       = $clog2(MAX_BLOCKS + 1);
  localparam int DIV_W       = 34;
  localparam int DIV_CNT_W   = $clog2(DIV_W + 1);
  localparam int CFG_IDX_W   = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_ZONE_START     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZONE_BYTES     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_REQUEST    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROUNDING_MODE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_MULTIPLE = 3'd4;

  localparam logic [31:0] MAX_REQUEST_RESET  = 32'h4000_0000;
  localparam logic [31:0] BLOCK_MULT_RESET   = 32'd4096;

  localparam logic [1:0] RND_GRAIN    = 2'd0;
  localparam logic [1:0] RND_POW2     = 2'd1;
  localparam logic [1:0] RND_MULTIPLE = 2'd2;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_SIZE   = 3'd1;
  localparam logic [2:0] ST_NO_SPACE   = 3'd2;
  localparam logic [2:0] ST_TABLE_FULL = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd4;

  typedef struct packed {
    logic        mode;
    logic [31:0] request_bytes;
    logic [31:0] alignment;
    logic [31:0] free_address;
  } in_word_t;

  typedef struct packed {
    logic [31:0] block_address;
    logic [31:0] granted_bytes;
    logic [2:0]  status;
  } out_word_t;

  typedef struct packed {
    logic [31:0] zone_start;
    logic [31:0] zone_bytes;
    logic [31:0] max_request_bytes;
    logic [1:0]  rounding_mode;
    logic [31:0] block_multiple;
  } cfg_t;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] len;
  } entry_t;

  typedef struct packed {
    logic             go;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
  } stat_t;

  typedef enum logic [3:0] {
    S_IDLE, S_ROUND, S_POW2, S_MDIV, S_CHECK, S_GAP_RD, S_GAP_WAIT, S_GAP_DIV,
    S_GAP_EVAL, S_INS_RD, S_INS_WAIT, S_FREE_RD, S_FREE_WAIT, S_DEL_RD, S_DEL_WAIT,
    S_DONE
  } ctl_state_t;

  function automatic logic [DIV_W-1:0] grain_up(input logic [DIV_W-1:0] x);
    grain_up = ((x + DIV_W'(GRAIN_BYTES - 1)) / DIV_W'(GRAIN_BYTES)) * DIV_W'(GRAIN_BYTES);
  endfunction

endpackage

/* hw/rtl/bfra_ram.sv */
module bfra_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/bfra_div.sv */
module bfra_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  bfra_pkg::div_req_t        req,
  output logic                      done,
  output logic [bfra_pkg::DIV_W-1:0] rem
);

  logic [bfra_pkg::DIV_W-1:0]     rem_r, rem_nxt;
  logic [bfra_pkg::DIV_W-1:0]     quo_r, quo_nxt;
  logic [bfra_pkg::DIV_W-1:0]     dvs_r, dvs_nxt;
  logic [bfra_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                           run_r, run_nxt;
  logic                           done_r, done_nxt;
  logic [bfra_pkg::DIV_W:0]       trial;

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[bfra_pkg::DIV_W-1]};
    if (req.go) begin
      rem_nxt = '0;
      quo_nxt = req.dividend;
      dvs_nxt = req.divisor;
      cnt_nxt = bfra_pkg::DIV_CNT_W'(bfra_pkg::DIV_W);
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        trial = trial - {1'b0, dvs_r};
      end
      rem_nxt = trial[bfra_pkg::DIV_W-1:0];
      quo_nxt = {quo_r[bfra_pkg::DIV_W-2:0], 1'b0};
      cnt_nxt = cnt_r - bfra_pkg::DIV_CNT_W'(1);
      if (cnt_r == bfra_pkg::DIV_CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

/* hw/rtl/bfra_ctrl.sv */
module bfra_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  bfra_pkg::in_word_t         in_word,
  input  bfra_pkg::cfg_t             cfg,
  output logic                       busy,
  output logic                       out_valid,
  output bfra_pkg::out_word_t        out_word,
  output bfra_pkg::stat_t            stat,
  output bfra_pkg::div_req_t         div_req,
  input  logic                       div_done,
  input  logic [bfra_pkg::DIV_W-1:0] div_rem,
  output logic                       ram_we,
  output logic [bfra_pkg::IDX_W-1:0] ram_waddr,
  output bfra_pkg::entry_t           ram_wdata,
  output logic [bfra_pkg::IDX_W-1:0] ram_raddr,
  input  bfra_pkg::entry_t           ram_rdata
);

  localparam int W = bfra_pkg::DIV_W;
  localparam int CW = bfra_pkg::CNT_W;

  bfra_pkg::ctl_state_t state_r, state_nxt;
  bfra_pkg::in_word_t   in_r, in_nxt;
  logic [W-1:0]  len_r, len_nxt;
  logic [W-1:0]  pow_r, pow_nxt;
  logic [W-1:0]  align_r, align_nxt;
  logic [32:0]   zend_r, zend_nxt;
  logic [W-1:0]  prev_end_r, prev_end_nxt;
  logic [W-1:0]  cur_end_r, cur_end_nxt;
  logic [W-1:0]  lo_r, lo_nxt;
  logic [W-1:0]  hi_r, hi_nxt;
  logic          found_r, found_nxt;
  logic [31:0]   best_start_r, best_start_nxt;
  logic [W-1:0]  best_size_r, best_size_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [31:0]   res_addr_r, res_addr_nxt;
  logic [31:0]   res_len_r, res_len_nxt;
  logic [2:0]    res_st_r, res_st_nxt;

  logic [W-1:0]  zs_c, lo_c, hi_c, bm_c, len0_c, gap_c;
  logic [W:0]    s_c;
  logic [W+1:0]  end_c;
  logic [CW-1:0] km1_c;

  always_comb begin
    state_nxt      = state_r;
    in_nxt         = in_r;
    len_nxt        = len_r;
    pow_nxt        = pow_r;
    align_nxt      = align_r;
    zend_nxt       = zend_r;
    prev_end_nxt   = prev_end_r;
    cur_end_nxt    = cur_end_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    found_nxt      = found_r;
    best_start_nxt = best_start_r;
    best_size_nxt  = best_size_r;
    count_nxt      = count_r;
    i_nxt          = i_r;
    res_addr_nxt   = res_addr_r;
    res_len_nxt    = res_len_r;
    res_st_nxt     = res_st_r;
    div_req        = '0;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    ram_raddr      = i_r[bfra_pkg::IDX_W-1:0];
    zs_c           = {2'b0, cfg.zone_start};
    bm_c           = (cfg.block_multiple == '0) ? W'(1) : {2'b0, cfg.block_multiple};
    len0_c         = bfra_pkg::grain_up({2'b0, in_r.request_bytes});
    lo_c           = '0;
    hi_c           = '0;
    s_c            = '0;
    end_c          = '0;
    gap_c          = '0;
    km1_c          = i_r - CW'(1);

    unique case (state_r)
      bfra_pkg::S_IDLE: begin
        res_addr_nxt = '0;
        res_len_nxt  = '0;
        if (start) begin
          in_nxt = in_word;
          i_nxt  = '0;
          state_nxt = (in_word.mode == bfra_pkg::MODE_FREE) ? bfra_pkg::S_FREE_RD
                                                            : bfra_pkg::S_ROUND;
        end
      end
      bfra_pkg::S_ROUND: begin
        len_nxt = len0_c;
        if (in_r.request_bytes == '0 || in_r.request_bytes > cfg.max_request_bytes) begin
          res_st_nxt = bfra_pkg::ST_BAD_SIZE;
          state_nxt  = bfra_pkg::S_DONE;
        end else if (cfg.rounding_mode == bfra_pkg::RND_POW2) begin
          pow_nxt   = W'(1);
          state_nxt = bfra_pkg::S_POW2;
        end else if (cfg.rounding_mode == bfra_pkg::RND_MULTIPLE) begin
          div_req.go       = 1'b1;
          div_req.dividend = len0_c;
          div_req.divisor  = bm_c;
          state_nxt        = bfra_pkg::S_MDIV;
        end else begin
          state_nxt = bfra_pkg::S_CHECK;
        end
      end
      bfra_pkg::S_POW2: begin
        if (pow_r < len_r) begin
          pow_nxt = {pow_r[W-2:0], 1'b0};
        end else begin
          len_nxt   = pow_r;
          state_nxt = bfra_pkg::S_CHECK;
        end
      end
      bfra_pkg::S_MDIV: begin
        if (div_done) begin
          if (div_rem != '0) begin
            len_nxt = len_r + (bm_c - div_rem);
          end
          state_nxt = bfra_pkg::S_CHECK;
        end
      end
      bfra_pkg::S_CHECK: begin
        if (len_r > W'(33'h0_FFFF_FFFF)) begin
          res_st_nxt = bfra_pkg::ST_NO_SPACE;
          state_nxt  = bfra_pkg::S_DONE;
        end else if (count_r >= CW'(bfra_pkg::MAX_BLOCKS)) begin
          res_st_nxt = bfra_pkg::ST_TABLE_FULL;
          state_nxt  = bfra_pkg::S_DONE;
        end else begin
          align_nxt = (in_r.alignment == '0) ? W'(bfra_pkg::GRAIN_BYTES)
                                             : bfra_pkg::grain_up({2'b0, in_r.alignment});
          zend_nxt  = {1'b0, cfg.zone_start} + {1'b0, cfg.zone_bytes};
          if (zend_nxt > 33'h1_0000_0000) begin
            zend_nxt = 33'h1_0000_0000;
          end
          found_nxt = 1'b0;
          i_nxt     = '0;
          state_nxt = bfra_pkg::S_GAP_RD;
        end
      end
      bfra_pkg::S_GAP_RD: begin
        state_nxt = bfra_pkg::S_GAP_WAIT;
      end
      bfra_pkg::S_GAP_WAIT: begin
        lo_c = (i_r == '0) ? zs_c : prev_end_r;
        if (lo_c < zs_c) begin
          lo_c = zs_c;
        end
        if (i_r == count_r || {2'b0, ram_rdata.start} > {1'b0, zend_r}) begin
          hi_c = {1'b0, zend_r};
        end else begin
          hi_c = {2'b0, ram_rdata.start};
        end
        lo_nxt           = lo_c;
        hi_nxt           = hi_c;
        cur_end_nxt      = {2'b0, ram_rdata.start} + {2'b0, ram_rdata.len};
        div_req.go       = 1'b1;
        div_req.dividend = lo_c;
        div_req.divisor  = align_r;
        state_nxt        = bfra_pkg::S_GAP_DIV;
      end
      bfra_pkg::S_GAP_DIV: begin
        if (div_done) begin
          state_nxt = bfra_pkg::S_GAP_EVAL;
        end
      end
      bfra_pkg::S_GAP_EVAL: begin
        s_c = {1'b0, lo_r};
        if (div_rem != '0) begin
          s_c = s_c + {1'b0, align_r - div_rem};
        end
        end_c = {1'b0, s_c} + {2'b0, len_r};
        gap_c = hi_r - s_c[W-1:0];
        if (end_c <= {2'b0, hi_r} && (!found_r || gap_c < best_size_r)) begin
          found_nxt      = 1'b1;
          best_size_nxt  = gap_c;
          best_start_nxt = s_c[31:0];
        end
        prev_end_nxt = cur_end_r;
        if (i_r == count_r) begin
          if (!found_nxt) begin
            res_st_nxt = bfra_pkg::ST_NO_SPACE;
            state_nxt  = bfra_pkg::S_DONE;
          end else begin
            state_nxt = bfra_pkg::S_INS_RD;
          end
        end else begin
          i_nxt     = i_r + CW'(1);
          state_nxt = bfra_pkg::S_GAP_RD;
        end
      end
      bfra_pkg::S_INS_RD: begin
        ram_raddr = km1_c[bfra_pkg::IDX_W-1:0];
        if (i_r == '0) begin
          ram_we       = 1'b1;
          ram_waddr    = '0;
          ram_wdata    = {best_start_r, len_r[31:0]};
          count_nxt    = count_r + CW'(1);
          res_addr_nxt = best_start_r;
          res_len_nxt  = len_r[31:0];
          res_st_nxt   = bfra_pkg::ST_OK;
          state_nxt    = bfra_pkg::S_DONE;
        end else begin
          state_nxt = bfra_pkg::S_INS_WAIT;
        end
      end
      bfra_pkg::S_INS_WAIT: begin
        ram_we    = 1'b1;
        ram_waddr = i_r[bfra_pkg::IDX_W-1:0];
        if (ram_rdata.start > best_start_r) begin
          ram_wdata = ram_rdata;
          i_nxt     = km1_c;
          state_nxt = bfra_pkg::S_INS_RD;
        end else begin
          ram_wdata    = {best_start_r, len_r[31:0]};
          count_nxt    = count_r + CW'(1);
          res_addr_nxt = best_start_r;
          res_len_nxt  = len_r[31:0];
          res_st_nxt   = bfra_pkg::ST_OK;
          state_nxt    = bfra_pkg::S_DONE;
        end
      end
      bfra_pkg::S_FREE_RD: begin
        if (i_r == count_r) begin
          res_st_nxt = bfra_pkg::ST_NOT_FOUND;
          state_nxt  = bfra_pkg::S_DONE;
        end else begin
          state_nxt = bfra_pkg::S_FREE_WAIT;
        end
      end
      bfra_pkg::S_FREE_WAIT: begin
        i_nxt = i_r + CW'(1);
        if (ram_rdata.start == in_r.free_address) begin
          res_addr_nxt = ram_rdata.start;
          res_len_nxt  = ram_rdata.len;
          res_st_nxt   = bfra_pkg::ST_OK;
          state_nxt    = bfra_pkg::S_DEL_RD;
        end else begin
          state_nxt = bfra_pkg::S_FREE_RD;
        end
      end
      bfra_pkg::S_DEL_RD: begin
        if (i_r == count_r) begin
          count_nxt = count_r - CW'(1);
          state_nxt = bfra_pkg::S_DONE;
        end else begin
          state_nxt = bfra_pkg::S_DEL_WAIT;
        end
      end
      bfra_pkg::S_DEL_WAIT: begin
        ram_we    = 1'b1;
        ram_waddr = km1_c[bfra_pkg::IDX_W-1:0];
        ram_wdata = ram_rdata;
        i_nxt     = i_r + CW'(1);
        state_nxt = bfra_pkg::S_DEL_RD;
      end
      bfra_pkg::S_DONE: begin
        state_nxt = bfra_pkg::S_IDLE;
      end
      default: begin
        state_nxt = bfra_pkg::S_IDLE;
      end
    endcase

    if (state_r == bfra_pkg::S_GAP_EVAL && i_r == count_r && found_nxt) begin
      i_nxt = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bfra_pkg::S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    in_r         <= in_nxt;
    len_r        <= len_nxt;
    pow_r        <= pow_nxt;
    align_r      <= align_nxt;
    zend_r       <= zend_nxt;
    prev_end_r   <= prev_end_nxt;
    cur_end_r    <= cur_end_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    found_r      <= found_nxt;
    best_start_r <= best_start_nxt;
    best_size_r  <= best_size_nxt;
    i_r          <= i_nxt;
    res_addr_r   <= res_addr_nxt;
    res_len_r    <= res_len_nxt;
    res_st_r     <= res_st_nxt;
  end

  assign busy                   = (state_r != bfra_pkg::S_IDLE);
  assign out_valid              = (state_r == bfra_pkg::S_DONE);
  assign out_word.block_address = res_addr_r;
  assign out_word.granted_bytes = res_len_r;
  assign out_word.status        = res_st_r;
  assign stat.count             = count_r;

endmodule

/* hw/rtl/best_fit_region_allocator_unit.sv */
// Free: scans the table one entry at a time, then shifts the later entries down.
// Allocate: checks (block_count + 1) gaps, each through the shared remainder
// unit, then shifts later entries up to insert the new one, after rounding the size.
// One word at a time: busy stays high until the result strobe, then start is taken.
// The result is shown for one cycle on out_valid; the receiver cannot stall.
// Synchronous reset empties the table and loads the register defaults.
`include "best_fit_region_allocator_unit_defines.svh"

module best_fit_region_allocator_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  bfra_pkg::in_word_t                  in_word,
  output logic                                out_valid,
  output bfra_pkg::out_word_t                 out_word,
  input  logic                                cfg_we,
  input  logic [bfra_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [31:0]                         cfg_wdata
);

  bfra_pkg::cfg_t     cfg_r, cfg_nxt;
  bfra_pkg::stat_t    stat;
  bfra_pkg::div_req_t div_req;
  logic                          div_done;
  logic [bfra_pkg::DIV_W-1:0]    div_rem;
  logic                          ram_we;
  logic [bfra_pkg::IDX_W-1:0]    ram_waddr;
  logic [bfra_pkg::IDX_W-1:0]    ram_raddr;
  bfra_pkg::entry_t              ram_wdata;
  bfra_pkg::entry_t              ram_rdata;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        bfra_pkg::CFG_ZONE_START:     cfg_nxt.zone_start        = cfg_wdata;
        bfra_pkg::CFG_ZONE_BYTES:     cfg_nxt.zone_bytes        = cfg_wdata;
        bfra_pkg::CFG_MAX_REQUEST:    cfg_nxt.max_request_bytes = cfg_wdata;
        bfra_pkg::CFG_ROUNDING_MODE:  cfg_nxt.rounding_mode     = cfg_wdata[1:0];
        bfra_pkg::CFG_BLOCK_MULTIPLE: cfg_nxt.block_multiple    = cfg_wdata;
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.zone_start        <= '0;
      cfg_r.zone_bytes        <= '0;
      cfg_r.max_request_bytes <= bfra_pkg::MAX_REQUEST_RESET;
      cfg_r.rounding_mode     <= bfra_pkg::RND_GRAIN;
      cfg_r.block_multiple    <= bfra_pkg::BLOCK_MULT_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  bfra_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_word   (in_word),
    .cfg       (cfg_r),
    .busy      (busy),
    .out_valid (out_valid),
    .out_word  (out_word),
    .stat      (stat),
    .div_req   (div_req),
    .div_done  (div_done),
    .div_rem   (div_rem),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  bfra_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .rem   (div_rem)
  );

  bfra_ram #(
    .WIDTH ($bits(bfra_pkg::entry_t)),
    .DEPTH (bfra_pkg::MAX_BLOCKS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  `BFRA_ASSERT(a_out_while_busy, clk, rst_n, out_valid |-> busy, "result outside a busy window")
  `BFRA_ASSERT(a_out_single, clk, rst_n, out_valid |=> !out_valid, "result strobe held")
  `BFRA_ASSERT(a_start_busy, clk, rst_n, (start && !busy) |=> busy, "accepted word not busy")
  `BFRA_ASSERT_ALWAYS(a_count_max, clk, (!rst_n) || (stat.count <= bfra_pkg::CNT_W'(bfra_pkg::MAX_BLOCKS)), "table overrun")

endmodule
